>>> hdl/lbc_pkg.sv
// Package for the LRU block buffer cache: command and status codes,
// the table entry record and the control/status structs linking ctrl and dpath.
`default_nettype none

package lbc_pkg;

  localparam int DEV_W   = 8;
  localparam int BLK_W   = 32;
  localparam int CNT_W   = 8;
  localparam int TICK_W  = 32;
  localparam int SEL_W   = 5;
  localparam int IDX_W   = 5;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX  = 8'd255;
  localparam logic [CNT_W-1:0] COUNT_ZERO = 8'd0;
  localparam logic [CNT_W-1:0] COUNT_ONE  = 8'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_PIN     = 2'd2,
    CMD_UNPIN   = 2'd3
  } lbc_op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_COUNT_ERR = 2'd2
  } lbc_status_t;

  typedef struct packed {
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
    logic              assigned;
    logic              loaded;
    logic [CNT_W-1:0]  count;
    logic [TICK_W-1:0] stamp;
  } lbc_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the accepted request, reset the scan
    logic issue;    // read one table entry this cycle
    logic commit;   // write back and load the result register
  } lbc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_issue;  // the read issued this cycle is the final one
  } lbc_sts_t;

endpackage

`default_nettype wire

>>> hdl/lru_block_buffer_cache_top.sv
// Top level of the LRU block buffer cache tag table.
// Instantiates lbc_ctrl and lbc_dpath; uses lbc_pkg.
`default_nettype none

// The block keeps ENTRY_COUNT buffer entries in a single-port table memory and
// serves one request at a time. A get request (cmd 0) walks the whole table,
// one entry per clock through the memory's registered read port, looking for
// the lowest entry that matches device and block, and at the same time for the
// unused entry with the oldest release stamp not above now_tick (ties go to
// the highest index). A get goes through an accept state, one read per entry,
// a drain state for the last read's data and a commit state that writes back
// and loads the result. Release, pin and unpin read only the selected entry.
// The result sits in an output register, so a new request is taken while the
// previous result still waits on out_stall; only the write-back waits for that
// register to drain. After reset every entry reads as unassigned with zero
// count and stamp: per-entry valid bits stand in for a clearing pass, so the
// block takes requests in the first cycle after reset. Status 1 means no free
// entry for a get; status 2 flags a user count that would wrap, or a select
// beyond the table.

module lru_block_buffer_cache_top
  import lbc_pkg::*;
#(
  parameter int ENTRY_COUNT = 32
)
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [CMD_W-1:0]   in_cmd,
  input  wire logic [DEV_W-1:0]   in_device_id,
  input  wire logic [BLK_W-1:0]   in_block_number,
  input  wire logic [SEL_W-1:0]   in_entry_select,
  input  wire logic [TICK_W-1:0]  in_now_tick,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [IDX_W-1:0]        out_entry_index,
  output logic                    out_was_hit,
  output logic                    out_needs_read,
  output logic [STAT_W-1:0]       out_status
);

  lbc_cmd_t cmd;
  lbc_sts_t sts;

  // sequencing: accept, scan, drain, commit
  lbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // table, scan and update
  lbc_dpath #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_cmd          (in_cmd),
    .in_device_id    (in_device_id),
    .in_block_number (in_block_number),
    .in_entry_select (in_entry_select),
    .in_now_tick     (in_now_tick),
    .out_entry_index (out_entry_index),
    .out_was_hit     (out_was_hit),
    .out_needs_read  (out_needs_read),
    .out_status      (out_status)
  );

`ifndef NO_ASSERTIONS
  // one request in flight: an accepted request closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in flight");

  // a commit always presents a result on the next cycle
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("commit without a result");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_NO_FREE ||
                   out_status == ST_COUNT_ERR))
    else $error("undefined status code");

  // a failed get reports entry zero with no hit and no read
  a_no_free_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_NO_FREE) |->
      (out_entry_index == '0 && !out_was_hit && !out_needs_read))
    else $error("no-free result carries stray fields");
`endif

endmodule

`default_nettype wire

>>> hdl/lbc_ctrl.sv
// Controller for the LRU block buffer cache: request handshake, scan sequencing
// and result handshake. Uses lbc_pkg; drives the datapath through lbc_cmd_t.
`default_nettype none

module lbc_ctrl
  import lbc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  output lbc_cmd_t      cmd,
  input  wire lbc_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } lbc_state_t;

  lbc_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        cmd.issue = 1'b1;
        if (sts.last_issue) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the result register can take the new result
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/lbc_dpath.sv
// Datapath for the LRU block buffer cache: entry table memory with valid bits,
// match and victim scan, update logic and result register. Uses lbc_pkg.
`default_nettype none

module lbc_dpath
  import lbc_pkg::*;
#(
  parameter int ENTRY_COUNT = 32
)
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lbc_cmd_t           cmd,
  output lbc_sts_t                sts,
  input  wire logic [CMD_W-1:0]   in_cmd,
  input  wire logic [DEV_W-1:0]   in_device_id,
  input  wire logic [BLK_W-1:0]   in_block_number,
  input  wire logic [SEL_W-1:0]   in_entry_select,
  input  wire logic [TICK_W-1:0]  in_now_tick,
  output logic [IDX_W-1:0]        out_entry_index,
  output logic                    out_was_hit,
  output logic                    out_needs_read,
  output logic [STAT_W-1:0]       out_status
);

  localparam int IW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRY_COUNT - 1);

  // entry table
  lbc_entry_t             mem [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] vld_r;

  // request registers
  lbc_op_t            op_r;
  logic [DEV_W-1:0]   dev_r;
  logic [BLK_W-1:0]   blk_r;
  logic [SEL_W-1:0]   sel_r;
  logic [IW-1:0]      sel_addr_r;
  logic               sel_ok_r;
  logic [TICK_W-1:0]  now_r;

  // scan state
  logic [IW-1:0]      rd_idx_r;
  logic [IW-1:0]      eval_idx_r;
  logic               rd_pend_r;
  lbc_entry_t         rd_data_r;
  logic               rd_vld_r;
  logic               hit_r;
  logic [IW-1:0]      hit_idx_r;
  lbc_entry_t         hit_ent_r;
  logic               found_r;
  logic [IW-1:0]      best_idx_r;
  logic [TICK_W-1:0]  limit_r;

  logic [IW-1:0]      rd_addr;
  lbc_entry_t         ent;
  logic               is_get;
  logic               match;
  logic               free_ok;
  logic [IW+SEL_W-1:0] sel_wide;
  logic [IW+IDX_W-1:0] hit_wide;
  logic [IW+IDX_W-1:0] best_wide;

  // commit logic
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  lbc_entry_t         wr_data;
  logic [IDX_W-1:0]   res_idx;
  logic               res_hit;
  logic               res_rd;
  lbc_status_t        res_st;

  assign is_get    = (op_r == CMD_GET);
  assign sel_wide  = {{IW{1'b0}}, in_entry_select};
  assign hit_wide  = {{IDX_W{1'b0}}, hit_idx_r};
  assign best_wide = {{IDX_W{1'b0}}, best_idx_r};
  assign rd_addr   = is_get ? rd_idx_r : sel_addr_r;
  assign sts.last_issue = !is_get || (rd_idx_r == LAST_IDX);

  // entries never written read as the reset value
  assign ent     = rd_vld_r ? rd_data_r : '0;
  assign match   = ent.assigned && (ent.dev == dev_r) && (ent.blk == blk_r);
  assign free_ok = (ent.count == COUNT_ZERO) && (ent.stamp <= limit_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= lbc_op_t'(in_cmd);
      dev_r      <= in_device_id;
      blk_r      <= in_block_number;
      sel_r      <= in_entry_select;
      sel_addr_r <= sel_wide[IW-1:0];
      sel_ok_r   <= (32'(in_entry_select) < ENTRY_COUNT);
      now_r      <= in_now_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
      hit_r     <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      rd_pend_r <= cmd.issue;
      if (cmd.capture) begin
        hit_r   <= 1'b0;
        found_r <= 1'b0;
      end else if (rd_pend_r) begin
        if (!is_get || (match && !hit_r)) begin
          hit_r <= 1'b1;
        end
        if (is_get && free_ok) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_idx_r <= '0;
      limit_r  <= in_now_tick;
    end else begin
      if (cmd.issue) begin
        rd_idx_r <= rd_idx_r + IW'(1);
      end
      if (rd_pend_r) begin
        if (!is_get || (match && !hit_r)) begin
          hit_idx_r <= eval_idx_r;
          hit_ent_r <= ent;
        end
        // <= keeps the later entry on equal stamps
        if (is_get && free_ok) begin
          best_idx_r <= eval_idx_r;
          limit_r    <= ent.stamp;
        end
      end
    end
  end

  // single read port, registered data
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data_r  <= mem[rd_addr];
      rd_vld_r   <= vld_r[rd_addr];
      eval_idx_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.commit && wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hit_idx_r;
    wr_data = hit_ent_r;
    res_idx = hit_wide[IDX_W-1:0];
    res_hit = 1'b0;
    res_rd  = 1'b0;
    res_st  = ST_OK;
    if (is_get) begin
      if (hit_r) begin
        res_hit = 1'b1;
        if (hit_ent_r.count == COUNT_MAX) begin
          res_st = ST_COUNT_ERR;
        end else begin
          wr_en          = 1'b1;
          wr_data.count  = hit_ent_r.count + COUNT_ONE;
          wr_data.loaded = 1'b1;
          res_rd         = !hit_ent_r.loaded;
        end
      end else if (found_r) begin
        wr_en            = 1'b1;
        wr_addr          = best_idx_r;
        wr_data.dev      = dev_r;
        wr_data.blk      = blk_r;
        wr_data.assigned = 1'b1;
        wr_data.loaded   = 1'b1;
        wr_data.count    = COUNT_ONE;
        wr_data.stamp    = limit_r;
        res_idx          = best_wide[IDX_W-1:0];
        res_rd           = 1'b1;
      end else begin
        res_idx = '0;
        res_st  = ST_NO_FREE;
      end
    end else begin
      wr_addr = sel_addr_r;
      res_idx = sel_r;
      if (!sel_ok_r) begin
        res_st = ST_COUNT_ERR;
      end else begin
        unique case (op_r)
          CMD_PIN: begin
            if (hit_ent_r.count == COUNT_MAX) begin
              res_st = ST_COUNT_ERR;
            end else begin
              wr_en         = 1'b1;
              wr_data.count = hit_ent_r.count + COUNT_ONE;
            end
          end
          CMD_RELEASE, CMD_UNPIN: begin
            if (hit_ent_r.count == COUNT_ZERO) begin
              res_st = ST_COUNT_ERR;
            end else begin
              wr_en         = 1'b1;
              wr_data.count = hit_ent_r.count - COUNT_ONE;
              if (op_r == CMD_RELEASE && hit_ent_r.count == COUNT_ONE) begin
                wr_data.stamp = now_r;
              end
            end
          end
          default: begin
            res_st = ST_OK;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_entry_index <= res_idx;
      out_was_hit     <= res_hit;
      out_needs_read  <= res_rd;
      out_status      <= res_st;
    end
  end

endmodule

`default_nettype wire

>>> tb/lru_block_buffer_cache_checker.sv
`timescale 1ns / 1ps
// Reply checker for the LRU block buffer cache: keeps its own copy of the tag table,
// predicts the reply to every accepted request and compares replies in order.
// Depends on lbc_pkg.

module lru_block_buffer_cache_checker
  import lbc_pkg::*;
#(
  parameter int ENTRY_COUNT = 32
)
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire logic [CMD_W-1:0]  in_cmd,
  input  wire logic [DEV_W-1:0]  in_device_id,
  input  wire logic [BLK_W-1:0]  in_block_number,
  input  wire logic [SEL_W-1:0]  in_entry_select,
  input  wire logic [TICK_W-1:0] in_now_tick,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire logic [IDX_W-1:0]  out_entry_index,
  input  wire logic              out_was_hit,
  input  wire logic              out_needs_read,
  input  wire logic [STAT_W-1:0] out_status,
  output int                     mismatch_count,
  output int                     replies_pending
);

  typedef struct packed {
    logic [IDX_W-1:0] entry_index;
    logic             was_hit;
    logic             needs_read;
    lbc_status_t      status;
  } cache_reply_t;

  lbc_entry_t   tag_table [ENTRY_COUNT];
  cache_reply_t expected_replies [$];
  int           fail_total = 0;

  assign mismatch_count = fail_total;

  task automatic report_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    $display("[%0t] check failed: %s got %0h expected %0h", $time, what, got, want);
    fail_total++;
  endtask

  // Update the table copy for one request and return the reply it must produce.
  function automatic cache_reply_t predict_reply(input lbc_op_t op,
                                                 input logic [DEV_W-1:0] dev,
                                                 input logic [BLK_W-1:0] blk,
                                                 input logic [SEL_W-1:0] sel,
                                                 input logic [TICK_W-1:0] now);
    cache_reply_t      r;
    logic [TICK_W-1:0] oldest;
    int                victim;
    bit                have_victim;
    r = '0;
    r.status = ST_OK;
    if (op == CMD_GET) begin
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        if (tag_table[i].assigned && tag_table[i].dev == dev && tag_table[i].blk == blk) begin
          r.entry_index = IDX_W'(i);
          r.was_hit = 1'b1;
          if (tag_table[i].count >= COUNT_MAX) begin
            r.status = ST_COUNT_ERR;
          end else begin
            tag_table[i].count = tag_table[i].count + COUNT_ONE;
            r.needs_read = !tag_table[i].loaded;
            tag_table[i].loaded = 1'b1;
          end
          return r;
        end
      end
      // Oldest idle stamp not above now; ties resolve to the highest index.
      oldest = now;
      victim = 0;
      have_victim = 1'b0;
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        if (tag_table[i].count == COUNT_ZERO && tag_table[i].stamp <= oldest) begin
          victim = i;
          oldest = tag_table[i].stamp;
          have_victim = 1'b1;
        end
      end
      if (!have_victim) begin
        r.status = ST_NO_FREE;
        return r;
      end
      tag_table[victim].dev = dev;
      tag_table[victim].blk = blk;
      tag_table[victim].assigned = 1'b1;
      tag_table[victim].loaded = 1'b1;
      tag_table[victim].count = COUNT_ONE;
      r.entry_index = IDX_W'(victim);
      r.needs_read = 1'b1;
      return r;
    end
    r.entry_index = IDX_W'(sel);
    if (int'(sel) >= ENTRY_COUNT) begin
      r.status = ST_COUNT_ERR;
    end else if (op == CMD_PIN) begin
      if (tag_table[sel].count >= COUNT_MAX) r.status = ST_COUNT_ERR;
      else tag_table[sel].count = tag_table[sel].count + COUNT_ONE;
    end else if (tag_table[sel].count == COUNT_ZERO) begin
      r.status = ST_COUNT_ERR;
    end else begin
      tag_table[sel].count = tag_table[sel].count - COUNT_ONE;
      if (op == CMD_RELEASE && tag_table[sel].count == COUNT_ZERO) tag_table[sel].stamp = now;
    end
    return r;
  endfunction

  // Check the reply before taking the request of the same edge, so that a stray reply
  // is never matched against a request that has only just arrived.
  always @(posedge clk) begin
    cache_reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRY_COUNT; i++) tag_table[i] = '0;
      expected_replies.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          report_error("reply with no request waiting, entry_index", 32'(out_entry_index),
                       '0);
        end else begin
          want = expected_replies.pop_front();
          if (out_entry_index !== want.entry_index)
            report_error("entry_index", 32'(out_entry_index), 32'(want.entry_index));
          if (out_was_hit !== want.was_hit)
            report_error("was_hit", 32'(out_was_hit), 32'(want.was_hit));
          if (out_needs_read !== want.needs_read)
            report_error("needs_read", 32'(out_needs_read), 32'(want.needs_read));
          if (out_status !== want.status)
            report_error("status", 32'(out_status), 32'(want.status));
        end
      end
      if (in_valid && !in_stall)
        expected_replies.push_back(predict_reply(lbc_op_t'(in_cmd), in_device_id,
                                                 in_block_number, in_entry_select,
                                                 in_now_tick));
    end
    replies_pending = expected_replies.size();
  end

endmodule

>>> tb/lru_block_buffer_cache_top_test.sv
`timescale 1ns / 1ps
// Testbench top for lru_block_buffer_cache_top: drives get, release, pin and unpin
// requests with random gaps and output stalls, and gives the verdict.
// Depends on lbc_pkg, the block and lru_block_buffer_cache_checker.

module lru_block_buffer_cache_top_test;
  import lbc_pkg::*;

  localparam int ENTRY_COUNT     = 32;
  localparam int GET_CYCLES      = ENTRY_COUNT + 3;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int REQUEST_TARGET  = 1700;
  localparam int HAMMER_AFTER    = 700;
  localparam int PRESSURE_AFTER  = 400;
  localparam int PRESSURE_CYCLES = 400;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  in_cmd = '0;
  logic [DEV_W-1:0]  in_device_id = '0;
  logic [BLK_W-1:0]  in_block_number = '0;
  logic [SEL_W-1:0]  in_entry_select = '0;
  logic [TICK_W-1:0] in_now_tick = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [IDX_W-1:0]  out_entry_index;
  logic              out_was_hit;
  logic              out_needs_read;
  logic [STAT_W-1:0] out_status;

  int                mismatch_count;
  int                replies_pending;
  int                requests_taken = 0;
  int                requests_sent = 0;
  logic [IDX_W-1:0]  last_reply_entry = '0;
  logic [TICK_W-1:0] tick = '0;
  bit                sender_idles = 1'b0;

  lru_block_buffer_cache_top #(.ENTRY_COUNT(ENTRY_COUNT)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_device_id    (in_device_id),
    .in_block_number (in_block_number),
    .in_entry_select (in_entry_select),
    .in_now_tick     (in_now_tick),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_entry_index (out_entry_index),
    .out_was_hit     (out_was_hit),
    .out_needs_read  (out_needs_read),
    .out_status      (out_status)
  );

  lru_block_buffer_cache_checker #(.ENTRY_COUNT(ENTRY_COUNT)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_device_id    (in_device_id),
    .in_block_number (in_block_number),
    .in_entry_select (in_entry_select),
    .in_now_tick     (in_now_tick),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_entry_index (out_entry_index),
    .out_was_hit     (out_was_hit),
    .out_needs_read  (out_needs_read),
    .out_status      (out_status),
    .mismatch_count  (mismatch_count),
    .replies_pending (replies_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Count handshakes at the edge; the stimulus reads these at the falling edge.
  // Keep the entry of the latest reply so a hammered entry can be addressed later.
  always @(posedge clk) begin
    if (!rst_n) begin
      requests_taken <= 0;
    end else begin
      if (in_valid && !in_stall) requests_taken <= requests_taken + 1;
      if (out_valid && !out_stall) last_reply_entry <= out_entry_index;
    end
  end

  // Watchdog: end the run if the block hangs or a reply never shows up.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // Draw devices mostly from a tiny set so that gets hit each other.
  function automatic logic [DEV_W-1:0] pick_device();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '1;
    if (r == 1) return DEV_W'($urandom);
    return DEV_W'($urandom_range(0, 3));
  endfunction

  // Draw blocks from a small pool, with the extremes and a full-width value now and then.
  function automatic logic [BLK_W-1:0] pick_block();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '1;
    if (r == 1) return '0;
    if (r == 2) return $urandom;
    return BLK_W'($urandom_range(0, 23));
  endfunction

  // Advance the tick slowly; now and then jump anywhere or show the top value, so that
  // some release stamps lie ahead of the current tick and block their entries.
  function automatic logic [TICK_W-1:0] next_now();
    int unsigned r;
    r = $urandom_range(0, 39);
    if (r == 0) tick = $urandom;
    else if (r == 1) return '1;
    else if (r == 2) return '0;
    else tick = tick + $urandom_range(0, 3);
    return tick;
  endfunction

  // Offer one request after an optional idle gap and hold it until it is taken.
  // Valid stays high on return so that back-to-back requests need no extra edge.
  task automatic offer(input lbc_op_t op, input logic [DEV_W-1:0] dev,
                       input logic [BLK_W-1:0] blk, input logic [SEL_W-1:0] sel,
                       input logic [TICK_W-1:0] now);
    int taken_before;
    int idle;
    int unsigned r;
    idle = 0;
    if (sender_idles) begin
      r = $urandom_range(0, 19);
      if (r >= 18) idle = $urandom_range(10, 50);
      else if (r >= 12) idle = $urandom_range(1, 3);
    end
    if (idle > 0) begin
      in_valid = 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid = 1'b1;
    in_cmd = op;
    in_device_id = dev;
    in_block_number = blk;
    in_entry_select = sel;
    in_now_tick = now;
    taken_before = requests_taken;
    do @(negedge clk); while (requests_taken == taken_before);
    requests_sent++;
  endtask

  // Receiver: short stalls mostly, a few long ones, stretches with none at all, and
  // once a long hold-off so that the result register fills and the block stalls input.
  initial begin
    int run;
    int hold;
    int unsigned r;
    bit pressure_done;
    pressure_done = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (!pressure_done && requests_taken >= PRESSURE_AFTER) begin
        out_stall = 1'b1;
        repeat (PRESSURE_CYCLES) @(negedge clk);
        pressure_done = 1'b1;
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6);
      r = $urandom_range(0, 19);
      if (r < 14) hold = $urandom_range(1, 2);
      else if (r < 19) hold = $urandom_range(3, 8);
      else hold = $urandom_range(20, 60);
      out_stall = 1'b0;
      repeat (run) @(negedge clk);
      out_stall = 1'b1;
      repeat (hold) @(negedge clk);
    end
  end

  // Stimulus: reset, a directed opening, random segments with one count hammer, verdict.
  initial begin
    int kind;
    int seg_len;
    int unsigned r;
    lbc_op_t op;
    bit hammer_done;
    logic [IDX_W-1:0] hammer_entry;
    hammer_done = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opening; the comments give the entry each get should land on.
    offer(CMD_GET, '0, '0, SEL_W'($urandom), '0);    // miss on an empty table: top entry
    offer(CMD_GET, '0, '0, SEL_W'($urandom), '0);    // hit, already loaded
    offer(CMD_GET, '1, '1, SEL_W'($urandom), '1);    // extreme tag: next entry down
    offer(CMD_RELEASE, DEV_W'($urandom), $urandom, 5'd31, 32'd5);
    offer(CMD_RELEASE, DEV_W'($urandom), $urandom, 5'd31, 32'd100);  // to zero: stamp 100
    offer(CMD_RELEASE, DEV_W'($urandom), $urandom, 5'd31, 32'd101);  // underflow
    offer(CMD_UNPIN, DEV_W'($urandom), $urandom, 5'd0, '0);    // underflow on unused entry
    offer(CMD_PIN, DEV_W'($urandom), $urandom, 5'd0, '0);      // pin an unassigned entry
    offer(CMD_UNPIN, DEV_W'($urandom), $urandom, 5'd0, 32'd9); // to zero without stamping
    offer(CMD_PIN, DEV_W'($urandom), $urandom, 5'd31, '0);
    offer(CMD_UNPIN, DEV_W'($urandom), $urandom, 5'd31, '1);   // stamp stays at 100
    offer(CMD_GET, '0, '0, SEL_W'($urandom), 32'd50);          // hit on an idle entry
    offer(CMD_RELEASE, DEV_W'($urandom), $urandom, 5'd31, 32'd7);    // stamp 7
    offer(CMD_GET, 8'h01, 32'h1, SEL_W'($urandom), 32'd5);     // stamp 7 above now: skip it
    offer(CMD_GET, 8'h55, 32'h5555_5555, SEL_W'($urandom), 32'd7);   // oldest stamp wins
    offer(CMD_RELEASE, DEV_W'($urandom), $urandom, 5'd30, '1); // stamp at the top tick
    offer(CMD_GET, 8'hAA, 32'hAAAA_AAAA, SEL_W'($urandom), '1);
    offer(CMD_PIN, 8'hAA, 32'hAAAA_AAAA, 5'd30, '0);
    offer(CMD_UNPIN, 8'h55, 32'h5555_5555, 5'd30, '1);

    while (requests_sent < REQUEST_TARGET) begin
      if (!hammer_done && requests_sent >= HAMMER_AFTER) begin
        // Free the table, drive one tag's count past its maximum by get hits, pin it
        // over the top, then release it all the way down and twice more.
        sender_idles = 1'b0;
        repeat (3)
          for (int k = 0; k < ENTRY_COUNT; k++)
            offer(CMD_RELEASE, DEV_W'($urandom), $urandom, SEL_W'(k), next_now());
        repeat (int'(COUNT_MAX) + 3)
          offer(CMD_GET, 8'hA5, 32'hC0DE_F00D, SEL_W'($urandom), '1);
        // drop valid so the last get is not taken again while the replies drain
        in_valid = 1'b0;
        while (replies_pending != 0) @(negedge clk);
        hammer_entry = last_reply_entry;
        repeat (2) offer(CMD_PIN, DEV_W'($urandom), $urandom, hammer_entry, next_now());
        repeat (int'(COUNT_MAX) + 2)
          offer(CMD_RELEASE, DEV_W'($urandom), $urandom, hammer_entry, next_now());
        hammer_done = 1'b1;
      end
      kind = $urandom_range(0, 9);
      seg_len = $urandom_range(10, 60);
      sender_idles = ($urandom_range(0, 3) != 0);
      case (kind)
        0, 1, 2: begin
          // fill: gets only, so the table runs out of free entries
          repeat (seg_len)
            offer(CMD_GET, pick_device(), pick_block(), SEL_W'($urandom), next_now());
        end
        3, 4, 5: begin
          repeat (seg_len) begin
            r = $urandom_range(0, 9);
            op = (r < 4) ? CMD_GET : (r < 7) ? CMD_RELEASE : (r < 9) ? CMD_PIN : CMD_UNPIN;
            offer(op, pick_device(), pick_block(), SEL_W'($urandom), next_now());
          end
        end
        6, 7: begin
          // drain: sweep the entries with releases and unpins
          for (int k = 0; k < seg_len; k++)
            offer(($urandom_range(0, 3) != 0) ? CMD_RELEASE : CMD_UNPIN, DEV_W'($urandom),
                  $urandom, SEL_W'(k % ENTRY_COUNT), next_now());
        end
        default: begin
          repeat (seg_len)
            offer(lbc_op_t'($urandom_range(0, 3)), DEV_W'($urandom), $urandom,
                  SEL_W'($urandom), $urandom);
        end
      endcase
    end

    in_valid = 1'b0;
    while (replies_pending != 0) @(negedge clk);
    repeat (2 * GET_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
